>>> rtl/bphr_pkg.sv
// ----------------------------------------------------------------------------
// bphr_pkg
// Shared types and constants of the button press / hold / repeat qualifier.
// ----------------------------------------------------------------------------
package bphr_pkg;

  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  // qualified button states
  localparam logic [ST_W-1:0] ST_RELEASED = 2'd0;
  localparam logic [ST_W-1:0] ST_PRESSED  = 2'd1;
  localparam logic [ST_W-1:0] ST_HELD     = 2'd2;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_HOLD_TICKS    = 2'd0;
  localparam logic [1:0] REG_REPEAT_TICKS  = 2'd1;
  localparam logic [1:0] REG_REPEAT_MASK   = 2'd2;
  localparam logic [1:0] REG_PRESSED_LEVEL = 2'd3;

  // register reset values
  localparam logic [CNT_W-1:0]       HOLD_TICKS_RST    = 16'd100;
  localparam logic [CNT_W-1:0]       REPEAT_TICKS_RST  = 16'd50;
  localparam logic [NUM_BUTTONS-1:0] REPEAT_MASK_RST   = NUM_BUTTONS'(2);
  localparam logic                   PRESSED_LEVEL_RST = 1'b0;

  // samples come out of reset at the released level of the reset polarity
  localparam logic SAMPLE_RST = ~PRESSED_LEVEL_RST;

  typedef struct packed {
    logic [CNT_W-1:0]       hold_ticks;
    logic [CNT_W-1:0]       repeat_ticks;
    logic [NUM_BUTTONS-1:0] repeat_mask;
    logic                   pressed_level;
  } cfg_t;

endpackage

>>> rtl/bphr_if.sv
// ----------------------------------------------------------------------------
// bphr_if
// Valid/ready channels for pin samples in and qualified events out.
// ----------------------------------------------------------------------------
interface bphr_in_if import bphr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink (input valid, input pin_levels, output ready);
endinterface

interface bphr_out_if import bphr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [NUM_BUTTONS-1:0]      press_events;
  logic [NUM_BUTTONS-1:0]      repeat_events;
  logic [ST_W*NUM_BUTTONS-1:0] button_states;

  modport source (output valid, output press_events, output repeat_events,
                  output button_states, input ready);
  modport sink (input valid, input press_events, input repeat_events,
                input button_states, output ready);
endinterface

>>> rtl/bphr_cfg.sv
// ----------------------------------------------------------------------------
// bphr_cfg
// APB register file: hold and repeat periods, repeat enables, press polarity.
// ----------------------------------------------------------------------------
module bphr_cfg import bphr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_HOLD_TICKS:    cfg_d.hold_ticks    = pwdata[CNT_W-1:0];
        REG_REPEAT_TICKS:  cfg_d.repeat_ticks  = pwdata[CNT_W-1:0];
        REG_REPEAT_MASK:   cfg_d.repeat_mask   = pwdata[NUM_BUTTONS-1:0];
        REG_PRESSED_LEVEL: cfg_d.pressed_level = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_TICKS:    prdata = APB_DW'(cfg_q.hold_ticks);
      REG_REPEAT_TICKS:  prdata = APB_DW'(cfg_q.repeat_ticks);
      REG_REPEAT_MASK:   prdata = APB_DW'(cfg_q.repeat_mask);
      REG_PRESSED_LEVEL: prdata = APB_DW'(cfg_q.pressed_level);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks    <= HOLD_TICKS_RST;
      cfg_q.repeat_ticks  <= REPEAT_TICKS_RST;
      cfg_q.repeat_mask   <= REPEAT_MASK_RST;
      cfg_q.pressed_level <= PRESSED_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/bphr_button.sv
// ----------------------------------------------------------------------------
// bphr_button
// Per-button state: last sample, qualified state, hold and repeat counters.
// ----------------------------------------------------------------------------
module bphr_button import bphr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            sample_i,
  input  logic            repeat_en_i,
  input  cfg_t            cfg_i,
  output logic            press_ev_o,
  output logic            repeat_ev_o,
  output logic [ST_W-1:0] state_o
);

  logic             last_q;
  logic [ST_W-1:0]  state_q, state_d;
  logic [CNT_W-1:0] hold_q, hold_d;
  logic [CNT_W-1:0] rep_q, rep_d;
  logic             stable;
  logic             pressed;

  assign stable  = (sample_i == last_q);
  assign pressed = (sample_i == cfg_i.pressed_level);

  always_comb begin
    state_d     = state_q;
    hold_d      = hold_q;
    rep_d       = rep_q;
    press_ev_o  = 1'b0;
    repeat_ev_o = 1'b0;
    if (stable) begin
      case (state_q)
        ST_RELEASED: begin
          if (pressed) state_d = ST_PRESSED;
        end
        ST_PRESSED: begin
          if (pressed) begin
            press_ev_o = (hold_q == '0);
            if (hold_q >= cfg_i.hold_ticks) begin
              hold_d  = '0;
              state_d = ST_HELD;
            end else begin
              hold_d = hold_q + 1'b1;
            end
          end else begin
            hold_d  = '0;
            state_d = ST_RELEASED;
          end
        end
        ST_HELD: begin
          if (repeat_en_i) begin
            if (rep_q >= cfg_i.repeat_ticks) begin
              repeat_ev_o = 1'b1;
              rep_d       = CNT_W'(1);
            end else begin
              rep_d = rep_q + 1'b1;
            end
          end
          // repeat check comes first, so a repeat may pulse on the release tick
          if (!pressed) begin
            rep_d   = '0;
            state_d = ST_RELEASED;
          end
        end
        default: state_d = state_q;
      endcase
    end
  end

  assign state_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= SAMPLE_RST;
      state_q <= ST_RELEASED;
      hold_q  <= '0;
      rep_q   <= '0;
    end else if (en_i) begin
      last_q  <= sample_i;
      state_q <= state_d;
      hold_q  <= hold_d;
      rep_q   <= rep_d;
    end
  end

  a_press_from_fresh_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_ev_o |-> (state_q == ST_PRESSED) && (hold_q == '0))
    else $error("press event outside a fresh press");

  a_repeat_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    repeat_ev_o |-> (state_q == ST_HELD) && repeat_en_i)
    else $error("repeat event while not held or not enabled");

  a_released_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RELEASED) |-> (hold_q == '0) && (rep_q == '0))
    else $error("counters not clear in released state");

endmodule

>>> rtl/button_press_hold_repeat.sv
// ----------------------------------------------------------------------------
// button_press_hold_repeat
// Qualifies raw button pin samples into press, hold and auto-repeat events.
//
//   channel  dir  fields                                        handshake
//   in_i     in   pin_levels                                    valid/ready
//   out_o    out  press_events, repeat_events, button_states    valid/ready
//   apb      in   hold_ticks, repeat_ticks, repeat_mask,        psel/penable
//                 pressed_level at byte 0x0, 0x4, 0x8, 0xC
//
// One item per cycle sustained while out_o is not stalled; each item passes the
// input register, then per-button logic into the result register.
// Reset: all buttons released, samples at the released level, registers at
// their reset values.
// A stalled result holds; one further item waits in the input register, then
// in_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module button_press_hold_repeat import bphr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bphr_in_if.sink           in_i,
  bphr_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t                        cfg;
  logic                        in_valid_q;
  logic [NUM_BUTTONS-1:0]      pins_q;
  logic                        out_valid_q;
  logic [NUM_BUTTONS-1:0]      press_q, press_d;
  logic [NUM_BUTTONS-1:0]      rep_q, rep_d;
  logic [ST_W*NUM_BUTTONS-1:0] states_q, states_d;
  logic                        advance;

  bphr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    bphr_button u_btn (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (advance),
      .sample_i    (pins_q[b]),
      .repeat_en_i (cfg.repeat_mask[b]),
      .cfg_i       (cfg),
      .press_ev_o  (press_d[b]),
      .repeat_ev_o (rep_d[b]),
      .state_o     (states_d[ST_W*b +: ST_W])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) pins_q <= in_i.pin_levels;
    if (advance) begin
      press_q  <= press_d;
      rep_q    <= rep_d;
      states_q <= states_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.press_events  = press_q;
  assign out_o.repeat_events = rep_q;
  assign out_o.button_states = states_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button press / hold / repeat qualifier. Pin
// samples go in through a valid/ready channel. Every accepted item is run
// through a local copy of the qualifier, and the predicted press, repeat and
// state fields are compared with each result item taken off the output
// channel. Directed runs cover the default set-up, hold and repeat, zero
// limits and limits lowered under a running count. Random runs with debounced
// pin traffic, glitches and noise then follow under three idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import bphr_pkg::*;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]      press_events;
    logic [NUM_BUTTONS-1:0]      repeat_events;
    logic [ST_W*NUM_BUTTONS-1:0] button_states;
  } qual_result_t;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 550;
  localparam int unsigned RECONFIG_EVERY  = 110;
  localparam int unsigned NOISE_SEGMENT   = 40;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bphr_in_if  sample_if ();
  bphr_out_if event_if ();

  button_press_hold_repeat dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (sample_if),
    .out_o   (event_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the qualifier
  cfg_t                   cfg_shadow;
  logic [NUM_BUTTONS-1:0] prev_level;
  logic [NUM_BUTTONS-1:0] cur_level;
  logic [ST_W-1:0]        btn_state  [NUM_BUTTONS];
  logic [CNT_W-1:0]       hold_cnt   [NUM_BUTTONS];
  logic [CNT_W-1:0]       repeat_cnt [NUM_BUTTONS];

  qual_result_t           expected_events_q [$];
  qual_result_t           want;
  int unsigned            src_idle_pct;
  int unsigned            rcv_stall_pct;
  int unsigned            fail_count;
  int unsigned            quiet_cycles = 0;
  logic [NUM_BUTTONS-1:0] steady_level;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic reset_model();
    cfg_shadow.hold_ticks    = HOLD_TICKS_RST;
    cfg_shadow.repeat_ticks  = REPEAT_TICKS_RST;
    cfg_shadow.repeat_mask   = REPEAT_MASK_RST;
    cfg_shadow.pressed_level = PRESSED_LEVEL_RST;
    prev_level = {NUM_BUTTONS{SAMPLE_RST}};
    cur_level  = {NUM_BUTTONS{SAMPLE_RST}};
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      btn_state[b]  = ST_RELEASED;
      hold_cnt[b]   = '0;
      repeat_cnt[b] = '0;
    end
  endtask

  // one sample tick; each button only moves when its sample repeats
  function automatic void qualify_sample(input logic [NUM_BUTTONS-1:0] pins);
    qual_result_t res;
    logic         pressed;
    res = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      prev_level[b] = cur_level[b];
      cur_level[b]  = pins[b];
      pressed       = (pins[b] == cfg_shadow.pressed_level);
      if (pins[b] == prev_level[b]) begin
        case (btn_state[b])
          ST_RELEASED: begin
            if (pressed) btn_state[b] = ST_PRESSED;
          end
          ST_PRESSED: begin
            if (pressed) begin
              if (hold_cnt[b] == '0) res.press_events[b] = 1'b1;
              if (hold_cnt[b] >= cfg_shadow.hold_ticks) begin
                hold_cnt[b]  = '0;
                btn_state[b] = ST_HELD;
              end else begin
                hold_cnt[b] = hold_cnt[b] + 1'b1;
              end
            end else begin
              hold_cnt[b]  = '0;
              btn_state[b] = ST_RELEASED;
            end
          end
          ST_HELD: begin
            // repeat check comes first, so the release tick may still repeat
            if (cfg_shadow.repeat_mask[b]) begin
              if (repeat_cnt[b] >= cfg_shadow.repeat_ticks) begin
                repeat_cnt[b]         = '0;
                res.repeat_events[b] = 1'b1;
              end
              repeat_cnt[b] = repeat_cnt[b] + 1'b1;
            end
            if (!pressed) begin
              repeat_cnt[b] = '0;
              btn_state[b]  = ST_RELEASED;
            end
          end
          default: ;
        endcase
      end
      res.button_states[ST_W*b +: ST_W] = btn_state[b];
    end
    expected_events_q.push_back(res);
  endfunction

  // debounced levels with the odd one-tick glitch, or plain noise
  function automatic logic [NUM_BUTTONS-1:0] next_pins(input bit noisy);
    logic [NUM_BUTTONS-1:0] pins;
    if (noisy) return NUM_BUTTONS'($urandom);
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if ($urandom_range(99) < 7) steady_level[b] = ~steady_level[b];
    end
    pins = steady_level;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if ($urandom_range(99) < 3) pins[b] = ~pins[b];
    end
    return pins;
  endfunction

  task automatic apply_sample(input logic [NUM_BUTTONS-1:0] pins);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid      <= 1'b1;
    sample_if.pin_levels <= pins;
    do @(posedge clk); while (!sample_if.ready);
    qualify_sample(pins);
  endtask

  task automatic apply_run(input logic [NUM_BUTTONS-1:0] pins, input int unsigned count);
    repeat (count) apply_sample(pins);
  endtask

  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (expected_events_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_HOLD_TICKS:    cfg_shadow.hold_ticks    = value[CNT_W-1:0];
      REG_REPEAT_TICKS:  cfg_shadow.repeat_ticks  = value[CNT_W-1:0];
      REG_REPEAT_MASK:   cfg_shadow.repeat_mask   = value[NUM_BUTTONS-1:0];
      REG_PRESSED_LEVEL: cfg_shadow.pressed_level = value[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CNT_W-1:0] hold, input logic [CNT_W-1:0] period,
                            input logic [NUM_BUTTONS-1:0] mask, input logic level);
    write_reg(REG_HOLD_TICKS, APB_DW'(hold));
    write_reg(REG_REPEAT_TICKS, APB_DW'(period));
    write_reg(REG_REPEAT_MASK, APB_DW'(mask));
    write_reg(REG_PRESSED_LEVEL, APB_DW'(level));
  endtask

  // reset values: active-low pins, button 0 pressed then released
  task automatic test_default_config();
    apply_sample(3'b111);
    apply_run(3'b110, 3);
    apply_run(3'b111, 2);
  endtask

  // active-high pins; button 1 held with its repeat masked off, the others
  // repeat every tick and once more on the releasing tick
  task automatic test_hold_and_repeat();
    wait_idle();
    set_config(16'd1, 16'd1, 3'b101, 1'b1);
    apply_run(3'b111, 7);
    apply_run(3'b010, 2);
  endtask

  task automatic test_limit_edges();
    // zero limits: held on the first counted tick, repeat on every held tick
    wait_idle();
    set_config('0, '0, 3'b111, 1'b0);
    apply_run(3'b000, 4);
    apply_run(3'b111, 2);
    // counts left above limits that are then lowered
    wait_idle();
    set_config('1, '1, 3'b111, 1'b0);
    apply_run(3'b000, 4);
    wait_idle();
    write_reg(REG_HOLD_TICKS, APB_DW'(1));
    apply_run(3'b000, 3);
    wait_idle();
    write_reg(REG_REPEAT_TICKS, APB_DW'(1));
    apply_run(3'b000, 1);
    apply_run(3'b111, 2);
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned rcv_pct);
    bit          noisy;
    logic [15:0] hold;
    noisy         = 1'b0;
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i % RECONFIG_EVERY == 0) begin
        wait_idle();
        hold = ($urandom_range(3) == 0) ? 16'($urandom_range(60, 20))
                                        : 16'($urandom_range(8));
        set_config(hold, CNT_W'($urandom_range(5)), NUM_BUTTONS'($urandom),
                   1'($urandom));
      end
      if (i % NOISE_SEGMENT == 0) noisy = ($urandom_range(99) < 15);
      apply_sample(next_pins(noisy));
    end
  endtask

  // result checker and output back-pressure
  always @(posedge clk) begin
    if (event_if.valid && event_if.ready) begin
      if (expected_events_q.size() == 0) begin
        $error("result item with none expected: press_events %0h repeat_events %0h %s %0h",
               event_if.press_events, event_if.repeat_events, "button_states",
               event_if.button_states);
        fail_count++;
      end else begin
        want = expected_events_q.pop_front();
        if (event_if.press_events !== want.press_events) begin
          $error("press_events: expected %0h, got %0h", want.press_events,
                 event_if.press_events);
          fail_count++;
        end
        if (event_if.repeat_events !== want.repeat_events) begin
          $error("repeat_events: expected %0h, got %0h", want.repeat_events,
                 event_if.repeat_events);
          fail_count++;
        end
        if (event_if.button_states !== want.button_states) begin
          $error("button_states: expected %0h, got %0h", want.button_states,
                 event_if.button_states);
          fail_count++;
        end
      end
    end
    event_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if ((sample_if.valid && sample_if.ready) || (event_if.valid && event_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    sample_if.valid      = 1'b0;
    sample_if.pin_levels = '0;
    event_if.ready       = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    src_idle_pct         = 36;
    rcv_stall_pct        = 58;
    fail_count           = 0;
    steady_level         = '1;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_hold_and_repeat();
    test_limit_edges();
    test_random_traffic(36, 58);
    test_random_traffic(58, 36);
    test_random_traffic(0, 0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_events_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bphr_pkg.sv
rtl/bphr_if.sv
rtl/bphr_cfg.sv
rtl/bphr_button.sv
rtl/button_press_hold_repeat.sv
dv/tb_top.sv
